// File: rtl/vref_pkg.sv
// Shared types, widths and helpers for the vector refraction pipeline.
package vref_pkg;

  localparam int QFRAC   = 14;
  localparam int RAD_W   = 40;  // radicand width of the square root
  localparam int ROOT_W  = 20;  // root width, one bit per stage
  localparam int REM_W   = 21;  // partial remainder width
  localparam int OUT_W   = 20;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic        [15:0] eta;
  } ray_t;

  // Data that rides alongside the square root
  typedef struct packed {
    ray_t               ray;
    logic signed [20:0] aci;   // round(eta * cosI), Q.14
    logic               tir;   // total internal reflection
  } sq_side_t;

  // Clamp a Q.14 sum to the signed 20-bit output range
  function automatic logic signed [OUT_W-1:0] sat20(input logic signed [24:0] v);
    logic signed [OUT_W-1:0] res;
    if (v > 25'sd524287) begin
      res = 20'sd524287;
    end else if (v < -25'sd524288) begin
      res = -20'sd524288;
    end else begin
      res = v[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/vref_sqrt.sv
// Pipelined integer square root, one root bit resolved per stage.
module vref_sqrt import vref_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [RAD_W-1:0]    in_rad,
  input  sq_side_t            in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ROOT_W-1:0]   out_root,
  output sq_side_t            out_side
);

  logic [ROOT_W-1:0]  v_r;
  logic [REM_W-1:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0]  root_r [ROOT_W];
  logic [RAD_W-1:0]   rad_r  [ROOT_W];
  sq_side_t           side_r [ROOT_W];

  logic [ROOT_W:0]    ld;
  logic [REM_W-1:0]   src_rem  [ROOT_W];
  logic [ROOT_W-1:0]  src_root [ROOT_W];
  logic [RAD_W-1:0]   src_rad  [ROOT_W];
  logic [REM_W+1:0]   rem_t    [ROOT_W];
  logic [REM_W+1:0]   trial    [ROOT_W];
  logic [REM_W+1:0]   diff     [ROOT_W];
  logic [ROOT_W-1:0]  ge;
  logic [REM_W-1:0]   rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0]  root_nxt [ROOT_W];
  logic [RAD_W-1:0]   rad_nxt  [ROOT_W];

  // Stage load enables: a stage loads when empty or when its beat moves on
  always_comb begin
    ld[ROOT_W] = out_ready;
    for (int j = ROOT_W - 1; j >= 0; j--) begin
      ld[j] = !v_r[j] || ld[j+1];
    end
  end

  assign in_ready = ld[0];

  // One restoring root step per stage
  always_comb begin
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_rad[0]  = in_rad;
    for (int j = 1; j < ROOT_W; j++) begin
      src_rem[j]  = rem_r[j-1];
      src_root[j] = root_r[j-1];
      src_rad[j]  = rad_r[j-1];
    end
    for (int j = 0; j < ROOT_W; j++) begin
      rem_t[j]    = {src_rem[j], src_rad[j][RAD_W-1 -: 2]};
      trial[j]    = {1'b0, src_root[j], 2'b01};
      ge[j]       = rem_t[j] >= trial[j];
      diff[j]     = rem_t[j] - trial[j];
      rem_nxt[j]  = ge[j] ? diff[j][REM_W-1:0] : rem_t[j][REM_W-1:0];
      root_nxt[j] = {src_root[j][ROOT_W-2:0], ge[j]};
      rad_nxt[j]  = {src_rad[j][RAD_W-3:0], 2'b00};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_valid;
      end
      for (int j = 1; j < ROOT_W; j++) begin
        if (ld[j]) begin
          v_r[j] <= v_r[j-1];
        end
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      side_r[0] <= in_side;
    end
    for (int j = 1; j < ROOT_W; j++) begin
      if (ld[j]) begin
        side_r[j] <= side_r[j-1];
      end
    end
    for (int j = 0; j < ROOT_W; j++) begin
      if (ld[j]) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        rad_r[j]  <= rad_nxt[j];
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

// File: rtl/vector_refraction_top.sv
// Snell refraction of a fixed-point 3D direction about a surface normal: a
// fully pipelined datapath that takes one ray per clock cycle unless in_stall
// is high, and passes each result through seven stages for the dot product
// and cosT2, twenty for the bit-per-stage square root and three for the final
// scale and sum. Stages that are empty fill even while the output is stalled,
// so bubbles are squeezed out; total internal reflection forces the vector to
// zero and raises out_total_reflect.
module vector_refraction_top import vref_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [15:0]      in_dir_x,
  input  logic signed [15:0]      in_dir_y,
  input  logic signed [15:0]      in_dir_z,
  input  logic signed [15:0]      in_norm_x,
  input  logic signed [15:0]      in_norm_y,
  input  logic signed [15:0]      in_norm_z,
  input  logic        [15:0]      in_eta,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_x,
  output logic signed [OUT_W-1:0] out_y,
  output logic signed [OUT_W-1:0] out_z,
  output logic                    out_total_reflect
);

  // Stage valid bits and load enables
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic sa_v_r, sb_v_r, out_valid_r;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld_a, ld_b, ld_out;
  logic sq_in_ready, sq_out_valid;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side_out, sq_side_in;

  ray_t ray_in;
  ray_t s1_ray_r, s2_ray_r, s3_ray_r, s4_ray_r, s5_ray_r, s6_ray_r, s7_ray_r;

  logic signed [31:0] p0_r, p1_r, p2_r;
  logic        [31:0] ee_r;
  logic signed [34:0] negdot;
  logic        [32:0] ee_rnd;
  logic signed [18:0] ci_r, ci_nxt;
  logic        [17:0] e2_r, e2_nxt, s3_e2_r, s4_e2_r;
  logic signed [37:0] cisq_r;
  logic signed [35:0] eci_r, eci_rnd;
  logic signed [37:0] om_full;
  logic signed [36:0] om_r;
  logic signed [20:0] s4_aci_r, s5_aci_r, s6_aci_r, s7_aci_r;
  logic        [35:0] plo_r;
  logic signed [37:0] phi_r;
  logic signed [55:0] prod_r;
  logic signed [42:0] ct2;
  logic               tir_nxt, s7_tir_r;
  logic [RAD_W-1:0]   s7_rad_r;

  logic signed [21:0] coeff_r;
  logic signed [32:0] ed_x_r, ed_y_r, ed_z_r, sb_ed_x_r, sb_ed_y_r, sb_ed_z_r;
  logic signed [37:0] cn_x_r, cn_y_r, cn_z_r;
  logic signed [15:0] sa_nx_r, sa_ny_r, sa_nz_r;
  logic               sa_tir_r, sb_tir_r;
  logic signed [38:0] sum_x, sum_y, sum_z;

  assign ray_in = '{dx: in_dir_x, dy: in_dir_y, dz: in_dir_z,
                    nx: in_norm_x, ny: in_norm_y, nz: in_norm_z, eta: in_eta};

  // Load enables ripple back from the output register
  assign ld_out   = !out_valid_r || !out_stall;
  assign ld_b     = !sb_v_r || ld_out;
  assign ld_a     = !sa_v_r || ld_b;
  assign ld7      = !s7_v_r || sq_in_ready;
  assign ld6      = !s6_v_r || ld7;
  assign ld5      = !s5_v_r || ld6;
  assign ld4      = !s4_v_r || ld5;
  assign ld3      = !s3_v_r || ld4;
  assign ld2      = !s2_v_r || ld3;
  assign ld1      = !s1_v_r || ld2;
  assign in_stall = !ld1;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0;
      s5_v_r <= 1'b0; s6_v_r <= 1'b0; s7_v_r <= 1'b0;
      sa_v_r <= 1'b0; sb_v_r <= 1'b0; out_valid_r <= 1'b0;
    end else begin
      if (ld1)    s1_v_r      <= in_valid;
      if (ld2)    s2_v_r      <= s1_v_r;
      if (ld3)    s3_v_r      <= s2_v_r;
      if (ld4)    s4_v_r      <= s3_v_r;
      if (ld5)    s5_v_r      <= s4_v_r;
      if (ld6)    s6_v_r      <= s5_v_r;
      if (ld7)    s7_v_r      <= s6_v_r;
      if (ld_a)   sa_v_r      <= sq_out_valid;
      if (ld_b)   sb_v_r      <= sa_v_r;
      if (ld_out) out_valid_r <= sb_v_r;
    end
  end

  // Stage 1: dot product terms and eta squared
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_ray_r <= ray_in;
      p0_r     <= in_dir_x * in_norm_x;
      p1_r     <= in_dir_y * in_norm_y;
      p2_r     <= in_dir_z * in_norm_z;
      ee_r     <= in_eta * in_eta;
    end
  end

  // Stage 2: cosI = round(-dot), e2 = round(eta^2)
  assign negdot = 35'sd8192 - p0_r - p1_r - p2_r;
  assign ci_nxt = negdot[32:14];
  assign ee_rnd = {1'b0, ee_r} + 33'd8192;
  assign e2_nxt = ee_rnd[31:14];

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_ray_r <= s1_ray_r;
      ci_r     <= ci_nxt;
      e2_r     <= e2_nxt;
    end
  end

  // Stage 3: cosI squared and eta * cosI
  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_ray_r <= s2_ray_r;
      s3_e2_r  <= e2_r;
      cisq_r   <= ci_r * ci_r;
      eci_r    <= $signed({1'b0, s2_ray_r.eta}) * ci_r;
    end
  end

  // Stage 4: one minus cosI squared, round eta * cosI
  assign om_full = 38'sd268435456 - cisq_r;
  assign eci_rnd = eci_r + 36'sd8192;

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_ray_r <= s3_ray_r;
      s4_e2_r  <= s3_e2_r;
      om_r     <= om_full[36:0];
      s4_aci_r <= eci_rnd[34:14];
    end
  end

  // Stage 5: e2 * om as two partial products
  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_ray_r <= s4_ray_r;
      s5_aci_r <= s4_aci_r;
      plo_r    <= s4_e2_r * om_r[17:0];
      phi_r    <= $signed({1'b0, s4_e2_r}) * $signed(om_r[36:18]);
    end
  end

  // Stage 6: join partial products, add rounding half
  always_ff @(posedge clk) begin
    if (ld6) begin
      s6_ray_r <= s5_ray_r;
      s6_aci_r <= s5_aci_r;
      prod_r   <= $signed({phi_r, 18'd0}) + $signed({20'd0, plo_r}) + 56'sd8192;
    end
  end

  // Stage 7: cosT2 and the reflection test
  assign ct2     = 43'sd268435456 - $signed({prod_r[55], prod_r[55:14]});
  assign tir_nxt = ct2[42] || (ct2 == 43'sd0);

  always_ff @(posedge clk) begin
    if (ld7) begin
      s7_ray_r <= s6_ray_r;
      s7_aci_r <= s6_aci_r;
      s7_tir_r <= tir_nxt;
      s7_rad_r <= tir_nxt ? '0 : ct2[RAD_W-1:0];
    end
  end

  assign sq_side_in = '{ray: s7_ray_r, aci: s7_aci_r, tir: s7_tir_r};

  vref_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s7_v_r),
    .in_ready  (sq_in_ready),
    .in_rad    (s7_rad_r),
    .in_side   (sq_side_in),
    .out_valid (sq_out_valid),
    .out_ready (ld_a),
    .out_root  (sq_root),
    .out_side  (sq_side_out)
  );

  // Stage A: coefficient and eta * dir
  always_ff @(posedge clk) begin
    if (ld_a) begin
      coeff_r  <= $signed({sq_side_out.aci[20], sq_side_out.aci})
                  - $signed({2'b00, sq_root});
      ed_x_r   <= $signed({1'b0, sq_side_out.ray.eta}) * sq_side_out.ray.dx;
      ed_y_r   <= $signed({1'b0, sq_side_out.ray.eta}) * sq_side_out.ray.dy;
      ed_z_r   <= $signed({1'b0, sq_side_out.ray.eta}) * sq_side_out.ray.dz;
      sa_nx_r  <= sq_side_out.ray.nx;
      sa_ny_r  <= sq_side_out.ray.ny;
      sa_nz_r  <= sq_side_out.ray.nz;
      sa_tir_r <= sq_side_out.tir;
    end
  end

  // Stage B: coefficient * normal
  always_ff @(posedge clk) begin
    if (ld_b) begin
      cn_x_r    <= coeff_r * sa_nx_r;
      cn_y_r    <= coeff_r * sa_ny_r;
      cn_z_r    <= coeff_r * sa_nz_r;
      sb_ed_x_r <= ed_x_r;
      sb_ed_y_r <= ed_y_r;
      sb_ed_z_r <= ed_z_r;
      sb_tir_r  <= sa_tir_r;
    end
  end

  // Output: sum, round, saturate; zero on reflection
  assign sum_x = sb_ed_x_r + cn_x_r + 39'sd8192;
  assign sum_y = sb_ed_y_r + cn_y_r + 39'sd8192;
  assign sum_z = sb_ed_z_r + cn_z_r + 39'sd8192;

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_x             <= sb_tir_r ? '0 : sat20(sum_x[38:14]);
      out_y             <= sb_tir_r ? '0 : sat20(sum_y[38:14]);
      out_z             <= sb_tir_r ? '0 : sat20(sum_z[38:14]);
      out_total_reflect <= sb_tir_r;
    end
  end

  assign out_valid = out_valid_r;

  // Reflected beats carry a zero vector
  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_total_reflect) |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("reflected beat with non-zero vector");

  // Input is held off only when the first stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with empty first stage");

  // A blocked stage keeps its beat
  a_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
    (sa_v_r && !ld_b) |=> (sa_v_r && $stable(coeff_r)))
    else $error("stage A beat lost while blocked");

  // The square root is never offered a beat it drops
  a_sq_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s7_v_r && !sq_in_ready) |=> (s7_v_r && $stable(s7_rad_r)))
    else $error("stage 7 beat lost while root pipeline full");

endmodule
